>>> sv/cbe_pkg.sv
// ----------------------------------------------------------------------------
// Critical band energy package
// Field widths, register indexes, opcodes and reset values shared by the
// channel interfaces and the block.
// ----------------------------------------------------------------------------
package cbe_pkg;

  localparam int EDGE_INDEX_W = 6;
  localparam int EDGE_BIN_W   = 15;
  localparam int BAND_INDEX_W = 5;
  localparam int ENERGY_W     = 48;
  localparam int ACC_W        = 64;
  localparam int FFT_LOG2_W   = 4;
  localparam int BAND_COUNT_W = 6;
  localparam int HALF_W       = 16;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 48;

  localparam logic OPCODE_LOAD = 1'b0;
  localparam logic OPCODE_BIN  = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_FFT_SIZE_LOG2   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BAND_COUNT      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_NOISE_THRESHOLD = 2'd2;

  localparam logic [FFT_LOG2_W-1:0]   FFT_SIZE_LOG2_RESET   = 4'd12;
  localparam logic [BAND_COUNT_W-1:0] BAND_COUNT_RESET      = 6'd25;
  localparam logic [ENERGY_W-1:0]     NOISE_THRESHOLD_RESET = '0;

  localparam logic [EDGE_BIN_W-1:0] BIN_COUNTER_MAX = '1;

endpackage

>>> sv/cbe_if.sv
// ----------------------------------------------------------------------------
// Critical band energy channel interfaces
// Valid/ready channels for input items, band results and register writes.
// ----------------------------------------------------------------------------
interface cbe_item_if #(parameter int SAMPLE_BITS = 24);
  import cbe_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [EDGE_INDEX_W-1:0]       edge_index;
  logic [EDGE_BIN_W-1:0]         edge_bin;
  logic signed [SAMPLE_BITS-1:0] bin_real;
  logic signed [SAMPLE_BITS-1:0] bin_imag;
  logic                          frame_end;

  modport source (output valid, opcode, edge_index, edge_bin, bin_real, bin_imag,
                  frame_end, input ready);
  modport sink   (input valid, opcode, edge_index, edge_bin, bin_real, bin_imag,
                  frame_end, output ready);
endinterface

interface cbe_result_if;
  import cbe_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [BAND_INDEX_W-1:0] band_index;
  logic [ENERGY_W-1:0]     band_power;
  logic                    last_band;

  modport source (output valid, band_index, band_power, last_band, input ready);
  modport sink   (input valid, band_index, band_power, last_band, output ready);
endinterface

interface cbe_cfg_if;
  import cbe_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/critical_band_energy.sv
// ----------------------------------------------------------------------------
// Critical band energy
// Sums the power of one spectral frame over loaded critical bands.
// ----------------------------------------------------------------------------
// The item channel carries edge loads and spectral bins. An edge load writes
// the edge memory. A bin is squared and summed; while a band is open, its
// upper edge is read, and a bin at or above it closes and reports the band
// before the next band is checked; else the lower edge is read, and a bin
// within the band and below half the FFT size is added. On the last bin of a
// frame every band still open is reported and the block rearms.
// Each result beat carries a band index, its energy and a last band flag.
// Results go through an output register, so the block keeps working while
// one result waits; it stalls only when a second result is ready before the
// first has been taken.
// Registers are written through the always ready cfg channel. The user must
// write them only while idle between beats; the block does not enforce it.
// Reset restores the register defaults and clears the band accumulator, the
// band pointer and the bin counter. The edge memory is not cleared and must
// be loaded before the first frame.
// ----------------------------------------------------------------------------
module critical_band_energy #(
  parameter int MAX_BANDS   = 32,
  parameter int SAMPLE_BITS = 24
) (
  input logic        clk,
  input logic        rst,
  cbe_item_if.sink   item,
  cbe_result_if.source result,
  cbe_cfg_if.sink    cfg
);
  import cbe_pkg::*;

  localparam int AW   = $clog2(MAX_BANDS + 1);
  localparam int SQ_W = 2 * SAMPLE_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_SQUARE, S_SUM, S_UP_RD, S_UP_CHK, S_LO_CHK, S_ADD, S_TAIL,
    S_SCALE, S_POST, S_FLUSH
  } state_t;

  state_t state;

  logic [FFT_LOG2_W-1:0]   fft_size_log2;
  logic [BAND_COUNT_W-1:0] band_count;
  logic [ENERGY_W-1:0]     noise_threshold;

  logic [EDGE_BIN_W-1:0] edge_mem [MAX_BANDS+1];
  logic [EDGE_BIN_W-1:0] rd_data;
  logic [AW-1:0]         mem_raddr;
  logic                  mem_we;

  logic [ACC_W-1:0]      acc;
  logic [AW-1:0]         cb;
  logic [EDGE_BIN_W-1:0] bin_counter;
  logic [EDGE_BIN_W-1:0] k;
  logic                  frame_end;
  logic                  flushing;

  logic signed [SAMPLE_BITS-1:0] re;
  logic signed [SAMPLE_BITS-1:0] im;
  logic [SQ_W-1:0]               sq_re;
  logic [SQ_W-1:0]               sq_im;
  logic [ACC_W-1:0]              mag;
  logic [ENERGY_W-1:0]           scaled;

  logic                    ovalid;
  logic [BAND_INDEX_W-1:0] oindex;
  logic [ENERGY_W-1:0]     oenergy;
  logic                    olast;

  logic                   item_acc;
  logic [AW-1:0]          bands;
  logic                   band_open;
  logic [HALF_W-1:0]      half;
  logic [SAMPLE_BITS-1:0] abs_re;
  logic [SAMPLE_BITS-1:0] abs_im;
  logic [ACC_W:0]         acc_sum;
  logic [ACC_W-1:0]       shifted;
  logic                   out_free;
  logic                   load_out;

  assign item.ready  = (state == S_IDLE);
  assign cfg.ready   = 1'b1;
  assign item_acc    = item.valid && item.ready;

  assign result.valid      = ovalid;
  assign result.band_index = oindex;
  assign result.band_power = oenergy;
  assign result.last_band  = olast;

  always_comb begin
    if (int'(band_count) > MAX_BANDS) begin
      bands = AW'(MAX_BANDS);
    end else begin
      bands = AW'(band_count);
    end
    band_open = (cb < bands);
    half      = (HALF_W'(1) << fft_size_log2) >> 1;
    abs_re    = re[SAMPLE_BITS-1] ? SAMPLE_BITS'(-re) : SAMPLE_BITS'(re);
    abs_im    = im[SAMPLE_BITS-1] ? SAMPLE_BITS'(-im) : SAMPLE_BITS'(im);
    acc_sum   = {1'b0, acc} + {1'b0, mag};
    shifted   = acc >> fft_size_log2;
    out_free  = !ovalid || result.ready;
    load_out  = (state == S_POST) && out_free;
    mem_we    = item_acc && (item.opcode == OPCODE_LOAD) &&
                (int'(item.edge_index) <= MAX_BANDS);
    mem_raddr = (state == S_UP_RD) ? AW'(cb + 1'b1) : cb;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      edge_mem[AW'(item.edge_index)] <= item.edge_bin;
    end
    rd_data <= edge_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      fft_size_log2   <= FFT_SIZE_LOG2_RESET;
      band_count      <= BAND_COUNT_RESET;
      noise_threshold <= NOISE_THRESHOLD_RESET;
      acc             <= '0;
      cb              <= '0;
      bin_counter     <= '0;
      flushing        <= 1'b0;
      ovalid          <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_FFT_SIZE_LOG2:   fft_size_log2   <= cfg.data[FFT_LOG2_W-1:0];
          REG_BAND_COUNT:      band_count      <= cfg.data[BAND_COUNT_W-1:0];
          REG_NOISE_THRESHOLD: noise_threshold <= cfg.data[ENERGY_W-1:0];
          default: ;
        endcase
      end

      if (ovalid && result.ready && !load_out) begin
        ovalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (item_acc && (item.opcode == OPCODE_BIN)) begin
            re        <= item.bin_real;
            im        <= item.bin_imag;
            frame_end <= item.frame_end;
            k         <= bin_counter;
            state     <= S_SQUARE;
          end
        end
        S_SQUARE: begin
          sq_re <= SQ_W'(abs_re) * SQ_W'(abs_re);
          sq_im <= SQ_W'(abs_im) * SQ_W'(abs_im);
          state <= S_SUM;
        end
        S_SUM: begin
          mag   <= ACC_W'(sq_re) + ACC_W'(sq_im);
          state <= S_UP_RD;
        end
        S_UP_RD: begin
          state <= band_open ? S_UP_CHK : S_TAIL;
        end
        S_UP_CHK: begin
          state <= (k >= rd_data) ? S_SCALE : S_LO_CHK;
        end
        S_LO_CHK: begin
          if ((k >= rd_data) && ({1'b0, k} < half)) begin
            state <= S_ADD;
          end else begin
            state <= S_TAIL;
          end
        end
        S_ADD: begin
          acc   <= acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
          state <= S_TAIL;
        end
        S_TAIL: begin
          if (bin_counter != BIN_COUNTER_MAX) begin
            bin_counter <= bin_counter + 1'b1;
          end
          if (frame_end) begin
            flushing <= 1'b1;
            state    <= S_FLUSH;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SCALE: begin
          scaled <= (|shifted[ACC_W-1:ENERGY_W]) ? '1 : shifted[ENERGY_W-1:0];
          state  <= S_POST;
        end
        S_POST: begin
          if (out_free) begin
            ovalid  <= 1'b1;
            oindex  <= BAND_INDEX_W'(cb);
            oenergy <= (scaled < noise_threshold) ? '0 : scaled;
            olast   <= (({1'b0, cb} + 1'b1) == {1'b0, bands});
            acc     <= '0;
            cb      <= cb + 1'b1;
            state   <= flushing ? S_FLUSH : S_UP_RD;
          end
        end
        S_FLUSH: begin
          if (band_open) begin
            state <= S_SCALE;
          end else begin
            acc         <= '0;
            cb          <= '0;
            bin_counter <= '0;
            flushing    <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!ovalid || result.ready))
    else $error("result register loaded while a beat is still pending");

  a_band_step: assert property (@(posedge clk) disable iff (rst)
    (cb != $past(cb)) |-> ((cb == AW'($past(cb) + 1'b1)) || (cb == '0)))
    else $error("band pointer moved by more than one band");

  a_no_accept_in_flush: assert property (@(posedge clk) disable iff (rst)
    item.ready |-> !flushing)
    else $error("item accepted during a frame flush");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> ((state == S_IDLE) && (cb == '0) && (acc == '0) && !ovalid))
    else $error("control state not cleared by reset");
`endif

endmodule
